// ----- sv/aes_pkg.sv -----
// Package: AES-128 types, S-box and round helpers
`timescale 1ns / 1ps
package aes_pkg;

	localparam int unsigned BlockW = 128;
	localparam int unsigned HalfW  = 64;
	localparam int unsigned Rounds = 10;
	localparam int unsigned CfgIdxW = 1;
	localparam logic [CfgIdxW-1:0] RegKeyHigh = 1'b0;
	localparam logic [CfgIdxW-1:0] RegKeyLow  = 1'b1;

	typedef logic [BlockW-1:0] block_t;
	typedef logic [7:0] byte_t;

	localparam byte_t SBOX [256] = '{
		8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
		8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
		8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
		8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
		8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
		8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
		8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
		8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
		8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
		8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
		8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
		8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
		8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
		8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
		8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
		8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16
	};

	localparam byte_t RCON [Rounds] = '{
		8'h01,8'h02,8'h04,8'h08,8'h10,8'h20,8'h40,8'h80,8'h1b,8'h36
	};

	// byte k of a block sits at bits [127-8k -: 8]
	function automatic byte_t get_byte(input block_t b, input int unsigned k);
		return b[BlockW-1-8*k -: 8];
	endfunction

	function automatic byte_t xtime(input byte_t b);
		return {b[6:0], 1'b0} ^ (b[7] ? 8'h1b : 8'h00);
	endfunction

	function automatic block_t next_key(input block_t rk, input byte_t rc);
		logic [31:0] w [4];
		logic [31:0] t;
		block_t r;
		for (int i = 0; i < 4; i++) w[i] = rk[BlockW-1-32*i -: 32];
		t = {SBOX[w[3][23:16]] ^ rc, SBOX[w[3][15:8]], SBOX[w[3][7:0]],
			SBOX[w[3][31:24]]};
		w[0] = w[0] ^ t;
		w[1] = w[1] ^ w[0];
		w[2] = w[2] ^ w[1];
		w[3] = w[3] ^ w[2];
		r = {w[0], w[1], w[2], w[3]};
		return r;
	endfunction

	function automatic block_t round_fn(input block_t s, input block_t rk,
		input logic last);
		byte_t t [16];
		byte_t a0, a1, a2, a3;
		block_t r;
		for (int c = 0; c < 4; c++)
			for (int q = 0; q < 4; q++)
				t[4*c+q] = SBOX[get_byte(s, 4*((c+q)%4)+q)];
		if (!last) begin
			for (int c = 0; c < 4; c++) begin
				a0 = t[4*c]; a1 = t[4*c+1]; a2 = t[4*c+2]; a3 = t[4*c+3];
				t[4*c]   = xtime(a0) ^ xtime(a1) ^ a1 ^ a2 ^ a3;
				t[4*c+1] = a0 ^ xtime(a1) ^ xtime(a2) ^ a2 ^ a3;
				t[4*c+2] = a0 ^ a1 ^ xtime(a2) ^ xtime(a3) ^ a3;
				t[4*c+3] = xtime(a0) ^ a0 ^ a1 ^ a2 ^ xtime(a3);
			end
		end
		for (int k = 0; k < 16; k++) r[BlockW-1-8*k -: 8] = t[k];
		return r ^ rk;
	endfunction

endpackage

// ----- sv/aes_stream_if.sv -----
// Interface: valid/ready channel carrying one 128-bit block as two halves
`timescale 1ns / 1ps
interface aes_stream_if;
	logic valid;
	logic ready;
	logic [aes_pkg::HalfW-1:0] high;
	logic [aes_pkg::HalfW-1:0] low;
	modport source (output valid, high, low, input ready);
	modport sink (input valid, high, low, output ready);
endinterface

// ----- sv/aes_round_cell.sv -----
// Round cell: one AES round with its own round key derivation
`timescale 1ns / 1ps
module aes_round_cell #(
	parameter int unsigned Round = 1
) (
	input  logic clk,
	input  logic arst_n,
	input  logic adv,
	input  logic vld_in,
	input  aes_pkg::block_t st_in,
	input  aes_pkg::block_t key_in,
	output logic vld_q,
	output aes_pkg::block_t st_q,
	output aes_pkg::block_t key_q
);
	aes_pkg::block_t key_nx;

	assign key_nx = aes_pkg::next_key(key_in, aes_pkg::RCON[Round-1]);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= 1'b0;
		end else if (adv) begin
			vld_q <= vld_in;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			key_q <= key_nx;
			st_q  <= aes_pkg::round_fn(st_in, key_nx, Round == aes_pkg::Rounds);
		end
	end
endmodule

// ----- sv/aes128_block_encrypt.sv -----
// Top level: pipelined AES-128 encryptor, a chain of ten round cells
`timescale 1ns / 1ps
// AES-128 (FIPS-197) encryption, one 128-bit block per request. The key is
// written through the config port (index 0 = key bytes 0..7, index 1 = bytes
// 8..15); the user must write it only while the block is idle, which the
// block itself does not enforce. Byte 0 of each half is in the top bits.
// An input stage does the initial AddRoundKey, then ten round cells; each
// cell carries the block and its round key to the next, so a new request is
// taken every cycle unless stalled; the result is registered by the input
// stage and ten cells, all stalled while the output holds an untaken result.
module aes128_block_encrypt (
	input  logic clk,
	input  logic arst_n,
	input  logic cfg_we,
	input  logic [aes_pkg::CfgIdxW-1:0] cfg_index,
	input  logic [aes_pkg::HalfW-1:0] cfg_data,
	aes_stream_if.sink   plain,
	aes_stream_if.source cipher
);
	localparam int unsigned N = aes_pkg::Rounds;

	logic [aes_pkg::HalfW-1:0] key_high_q, key_low_q;
	logic adv;
	logic vld_s [N+1];
	aes_pkg::block_t st_s [N+1];
	aes_pkg::block_t key_s [N+1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			key_high_q <= '0;
			key_low_q  <= '0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				aes_pkg::RegKeyHigh: key_high_q <= cfg_data;
				aes_pkg::RegKeyLow:  key_low_q  <= cfg_data;
				default: ;
			endcase
		end
	end

	// stall everything while the last stage holds an untaken result
	assign adv = !vld_s[N] || cipher.ready;
	assign plain.ready = adv;

	// input stage: initial AddRoundKey
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s[0] <= 1'b0;
		end else if (adv) begin
			vld_s[0] <= plain.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			key_s[0] <= {key_high_q, key_low_q};
			st_s[0]  <= {plain.high, plain.low} ^ {key_high_q, key_low_q};
		end
	end

	for (genvar g = 1; g <= N; g++) begin : g_cell
		aes_round_cell #(.Round(g)) u_cell (
			.clk(clk), .arst_n(arst_n), .adv(adv),
			.vld_in(vld_s[g-1]), .st_in(st_s[g-1]), .key_in(key_s[g-1]),
			.vld_q(vld_s[g]), .st_q(st_s[g]), .key_q(key_s[g])
		);
	end

	assign cipher.valid = vld_s[N];
	assign cipher.high  = st_s[N][aes_pkg::BlockW-1 -: aes_pkg::HalfW];
	assign cipher.low   = st_s[N][aes_pkg::HalfW-1:0];
endmodule
